/* sv/ptc_pkg.sv */
`default_nettype none

package ptc_pkg;

  localparam int RAW_W     = 12;
  localparam int MV_W      = 15;
  localparam int PROD_W    = 22;
  localparam int RECIP_W   = 23;
  localparam int FULL_W    = PROD_W + RECIP_W;
  localparam int MV_SHIFT  = 29;
  localparam int LOW_W     = 16;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int MAX_CH    = 8;

  // raw * 527 / 100, the division done as an exact reciprocal multiply
  localparam logic [PROD_W-1:0]  MV_MUL   = PROD_W'(527);
  localparam logic [RECIP_W-1:0] MV_RECIP = RECIP_W'(5368710);

  localparam logic [1:0] OPTIC_EDGES = 2'd3;
  localparam logic [2:0] THERM_EDGES = 3'd4;

  localparam logic [2:0] REG_THERM_THR = 3'd0;
  localparam logic [2:0] REG_OPTIC_THR = 3'd1;
  localparam logic [2:0] REG_HYST      = 3'd2;
  localparam logic [2:0] REG_OPTIC_LVL = 3'd3;
  localparam logic [2:0] REG_FIRST_CH  = 3'd4;

  typedef enum logic [1:0] {
    TYPE_NONE  = 2'd0,
    TYPE_THERM = 2'd1,
    TYPE_OPTIC = 2'd2
  } ptc_type_t;

  typedef struct packed {
    logic [MV_W-1:0] therm_thr;
    logic [MV_W-1:0] optic_thr;
    logic [MV_W-1:0] hyst;
    logic [MV_W-1:0] optic_level;
    logic [2:0]      first_channel;
  } ptc_cfg_t;

  typedef struct packed {
    logic active;
    logic dry;
    logic therm_try;
    logic seen_once;
  } ptc_lane_ctl_t;

  typedef struct packed {
    logic      level;
    logic      trans;
    logic      optic_now;
    logic      off_req;
    ptc_type_t ty;
  } ptc_lane_res_t;

  typedef struct packed {
    logic [RAW_W-1:0] sample_ch0;
    logic [RAW_W-1:0] sample_ch1;
    logic [RAW_W-1:0] sample_ch2;
    logic [RAW_W-1:0] sample_ch3;
    logic [RAW_W-1:0] sample_ch4;
    logic [RAW_W-1:0] sample_ch5;
    logic [RAW_W-1:0] sample_ch6;
    logic [RAW_W-1:0] sample_ch7;
    logic [7:0]       dry_mask;
    logic             thermistor_try;
    logic             dry_seen_once;
  } ptc_in_t;

  typedef struct packed {
    logic [7:0]  level_mask;
    logic [7:0]  transition_mask;
    logic [7:0]  optic_found_mask;
    logic [7:0]  current_off_mask;
    logic [15:0] type_codes;
    logic [3:0]  ring_slot;
  } ptc_out_t;

endpackage

`default_nettype wire

/* sv/ptc_if.sv */
`default_nettype none

interface ptc_in_if;
  import ptc_pkg::*;
  logic    valid;
  logic    ready;
  ptc_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ptc_out_if;
  import ptc_pkg::*;
  logic     valid;
  logic     ready;
  ptc_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* sv/probe_threshold_classifier.sv */
`default_nettype none

// probe threshold classifier: each item is one scan of eight 12-bit adc codes
// plus the dry mask and mode bits. every channel from first_channel upward is
// scaled to millivolts (raw*527/100), compared with its threshold under
// hysteresis, and its rising edges while dry build up the optic / thermistor
// classification. one result item leaves per scan with the level, transition,
// optic and current-off masks, the type codes and the ring slot that got the
// transition mask. a new scan is taken every clock cycle while no stall backs up to
// the input; a scan passes three register stages, the two multiplier stages of the
// millivolt scaling and the per-channel state stage that loads the output register.
// stages only hold while the output register is stalled, so bubbles still absorb
// new scans. configuration goes through the apb port at byte address 4*index, reads
// return the value.
module probe_threshold_classifier #(
  parameter int CHANNELS   = 8,
  parameter int RING_DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  ptc_in_if.sink                          in_ch,
  ptc_out_if.source                       out_ch,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ptc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ptc_pkg::DATA_W-1:0] pwdata,
  output logic      [ptc_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);
  import ptc_pkg::*;

  ptc_cfg_t        cfg;
  logic [RAW_W-1:0] raw [MAX_CH];

  // pipeline occupancy and side fields that travel with the scan
  logic            v1_r, v1_nxt, v2_r, v2_nxt;
  logic            en1, en2, take, upd;
  logic [7:0]      dry1_r, dry2_r;
  logic            try1_r, try2_r;
  logic            seen1_r, seen2_r;

  ptc_lane_res_t   res [CHANNELS];

  ptc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign raw[0] = in_ch.payload.sample_ch0;
  assign raw[1] = in_ch.payload.sample_ch1;
  assign raw[2] = in_ch.payload.sample_ch2;
  assign raw[3] = in_ch.payload.sample_ch3;
  assign raw[4] = in_ch.payload.sample_ch4;
  assign raw[5] = in_ch.payload.sample_ch5;
  assign raw[6] = in_ch.payload.sample_ch6;
  assign raw[7] = in_ch.payload.sample_ch7;

  // a stage loads when it is empty or its contents move on
  assign en2         = !v2_r || take;
  assign en1         = !v1_r || en2;
  assign in_ch.ready = en1;
  assign upd         = take && v2_r;

  assign v1_nxt = en1 ? in_ch.valid : v1_r;
  assign v2_nxt = en2 ? v1_r : v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      dry1_r  <= in_ch.payload.dry_mask;
      try1_r  <= in_ch.payload.thermistor_try;
      seen1_r <= in_ch.payload.dry_seen_once;
    end
    if (en2) begin
      dry2_r  <= dry1_r;
      try2_r  <= try1_r;
      seen2_r <= seen1_r;
    end
  end

  // one lane per channel; lanes below first_channel leave their state alone
  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
    ptc_lane_ctl_t ctl;

    assign ctl.active    = 3'(ch) >= cfg.first_channel;
    assign ctl.dry       = dry2_r[ch];
    assign ctl.therm_try = try2_r;
    assign ctl.seen_once = seen2_r;

    ptc_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .load1 (en1),
      .load2 (en2),
      .upd   (upd),
      .raw   (raw[ch]),
      .cfg   (cfg),
      .ctl   (ctl),
      .res   (res[ch])
    );
  end

  // merging stage: masks, optic accumulator, transition ring, output register
  ptc_merge #(
    .CHANNELS   (CHANNELS),
    .RING_DEPTH (RING_DEPTH)
  ) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (v2_r),
    .res         (res),
    .take        (take),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_payload (out_ch.payload)
  );

endmodule

`default_nettype wire

/* sv/ptc_regs.sv */
`default_nettype none

module ptc_regs (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [ptc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ptc_pkg::DATA_W-1:0] pwdata,
  output logic      [ptc_pkg::DATA_W-1:0] prdata,
  output logic                           pready,
  output ptc_pkg::ptc_cfg_t              cfg
);
  import ptc_pkg::*;

  ptc_cfg_t   cfg_r, cfg_nxt;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        REG_THERM_THR: cfg_nxt.therm_thr     = pwdata[MV_W-1:0];
        REG_OPTIC_THR: cfg_nxt.optic_thr     = pwdata[MV_W-1:0];
        REG_HYST:      cfg_nxt.hyst          = pwdata[MV_W-1:0];
        REG_OPTIC_LVL: cfg_nxt.optic_level   = pwdata[MV_W-1:0];
        REG_FIRST_CH:  cfg_nxt.first_channel = pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_THERM_THR: prdata = DATA_W'(cfg_r.therm_thr);
      REG_OPTIC_THR: prdata = DATA_W'(cfg_r.optic_thr);
      REG_HYST:      prdata = DATA_W'(cfg_r.hyst);
      REG_OPTIC_LVL: prdata = DATA_W'(cfg_r.optic_level);
      REG_FIRST_CH:  prdata = DATA_W'(cfg_r.first_channel);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/ptc_lane.sv */
`default_nettype none

module ptc_lane (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       load1,
  input  wire logic                       load2,
  input  wire logic                       upd,
  input  wire logic [ptc_pkg::RAW_W-1:0]  raw,
  input  wire ptc_pkg::ptc_cfg_t          cfg,
  input  wire ptc_pkg::ptc_lane_ctl_t     ctl,
  output ptc_pkg::ptc_lane_res_t          res
);
  import ptc_pkg::*;

  logic [PROD_W-1:0] prod_r;
  logic [FULL_W-1:0] full;
  logic [MV_W-1:0]   mv_r;

  logic [MV_W-1:0]   prev_r, prev_nxt;
  logic [1:0]        ocnt_r, ocnt_nxt;
  logic [2:0]        tcnt_r, tcnt_nxt;
  ptc_type_t         type_r, type_nxt;
  logic              level_r, level_nxt;

  logic [MV_W-1:0]   thr;
  logic [LOW_W-1:0]  low;
  logic              therm_ok, above, rise, fall;
  logic              trans, optic_now, off_req;

  // millivolt scaling, one multiply per stage
  assign full = FULL_W'(prod_r) * FULL_W'(MV_RECIP);

  always_ff @(posedge clk) begin
    if (load1) begin
      prod_r <= PROD_W'(raw) * MV_MUL;
    end
    if (load2) begin
      mv_r <= full[MV_SHIFT +: MV_W];
    end
  end

  assign therm_ok = (type_r == TYPE_NONE) || (type_r == TYPE_THERM);
  assign thr      = (ctl.therm_try && therm_ok) ? cfg.therm_thr : cfg.optic_thr;
  assign low      = LOW_W'(thr) - LOW_W'(cfg.hyst);
  assign above    = mv_r > thr;
  assign rise     = above && (LOW_W'(prev_r) <= low);
  assign fall     = (LOW_W'(mv_r) < low) && (prev_r >= thr);

  always_comb begin
    prev_nxt  = prev_r;
    ocnt_nxt  = ocnt_r;
    tcnt_nxt  = tcnt_r;
    type_nxt  = type_r;
    level_nxt = level_r;
    trans     = 1'b0;
    optic_now = 1'b0;
    off_req   = 1'b0;
    if (ctl.active) begin
      level_nxt = above;
      prev_nxt  = mv_r;
      if (rise) begin
        trans = 1'b1;
        if (ctl.dry) begin
          if (mv_r > cfg.optic_level) begin
            if (ocnt_r == OPTIC_EDGES) begin
              optic_now = 1'b1;
              type_nxt  = TYPE_OPTIC;
              tcnt_nxt  = '0;
              off_req   = !ctl.seen_once;
            end else begin
              ocnt_nxt = ocnt_r + 2'd1;
            end
          end else if (therm_ok) begin
            if (tcnt_r >= THERM_EDGES) begin
              type_nxt = TYPE_THERM;
              tcnt_nxt = THERM_EDGES;
            end else begin
              tcnt_nxt = tcnt_r + 3'd1;
            end
          end
        end
      end else if (fall) begin
        trans = 1'b1;
      end
    end
  end

  assign res.level     = level_nxt;
  assign res.trans     = trans;
  assign res.optic_now = optic_now;
  assign res.off_req   = off_req;
  assign res.ty        = type_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      ocnt_r  <= '0;
      tcnt_r  <= '0;
      type_r  <= TYPE_NONE;
      level_r <= 1'b0;
    end else if (upd) begin
      prev_r  <= prev_nxt;
      ocnt_r  <= ocnt_nxt;
      tcnt_r  <= tcnt_nxt;
      type_r  <= type_nxt;
      level_r <= level_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/ptc_merge.sv */
`default_nettype none

module ptc_merge #(
  parameter int CHANNELS   = 8,
  parameter int RING_DEPTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire ptc_pkg::ptc_lane_res_t res [CHANNELS],
  output logic                        take,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output ptc_pkg::ptc_out_t           out_payload
);
  import ptc_pkg::*;

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int EXT_W = (PTR_W > 4) ? PTR_W : 4;

  logic             out_valid_r, out_valid_nxt;
  ptc_out_t         out_r, out_nxt;
  logic [7:0]       accum_r, accum_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic [EXT_W-1:0] ptr_ext;
  logic [7:0]       ring_mem [RING_DEPTH];
  logic             load;

  assign take          = !out_valid_r || out_ready;
  assign load          = take && in_valid;
  assign out_valid_nxt = take ? in_valid : out_valid_r;
  assign ptr_ext       = EXT_W'(ptr_r);
  assign ptr_nxt       = (ptr_r == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_r + PTR_W'(1);

  always_comb begin
    out_nxt = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      out_nxt.level_mask[i]        = res[i].level;
      out_nxt.transition_mask[i]   = res[i].trans;
      out_nxt.current_off_mask[i]  = res[i].off_req;
      out_nxt.optic_found_mask[i]  = res[i].optic_now;
      out_nxt.type_codes[2*i +: 2] = res[i].ty;
    end
    accum_nxt                = accum_r | out_nxt.optic_found_mask;
    out_nxt.optic_found_mask = accum_nxt;
    out_nxt.ring_slot        = ptr_ext[3:0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r              <= out_nxt;
      ring_mem[ptr_r]    <= out_nxt.transition_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      accum_r     <= '0;
      ptr_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (load) begin
        accum_r <= accum_nxt;
        ptr_r   <= ptr_nxt;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

endmodule

`default_nettype wire
